@@ hw/rtl/pcr_pkg.sv @@
package pcr_pkg;

    localparam int SEGMENTS = 12;

    // Breakpoints in whole percent, one more than the segment count
    localparam logic [6:0] BREAK_PCT [SEGMENTS+1] = '{
        7'd0,  7'd5,  7'd10, 7'd20, 7'd30, 7'd40, 7'd50,
        7'd60, 7'd70, 7'd80, 7'd90, 7'd95, 7'd100
    };

    // Stop colors as RRGGBB, one per breakpoint
    localparam logic [23:0] STOP_RGB [SEGMENTS+1] = '{
        24'h003EFF, 24'h0094FF, 24'h00FFFF, 24'h00FF90, 24'h00FF21,
        24'h4CFF00, 24'hB6FF00, 24'hFFD800, 24'hFF6A00, 24'hFF2F00,
        24'hFF0000, 24'hFF006E, 24'hFD80B5
    };

    // Color for inputs at or above one hundred percent
    localparam logic [23:0] TOP_RGB = 24'hA71F00;

    // Segment width in percent that marks a ten-percent segment
    localparam logic [6:0] WIDE_PCT = 7'd10;

endpackage

@@ hw/rtl/pcr_front.sv @@
module pcr_front #(
    parameter int FRAC_BITS = 8,
    parameter int OFF_W     = 12,
    parameter int PROD_W    = 20
) (
    input  logic [15:0]             i_x,
    output logic [2:0][7:0]         o_base,
    output logic [2:0][PROD_W-1:0]  o_num,
    output logic                    o_wide
);

    // Find the segment, then form base and scaled numerator per channel
    always_comb begin
        logic [31:0]      x32;
        logic [31:0]      lo;
        logic [31:0]      hi;
        logic             hit;
        logic [3:0]       seg;
        logic [OFF_W-1:0] off;
        logic [OFF_W-1:0] span;
        logic [23:0]      s_rgb;
        logic [23:0]      e_rgb;
        logic [7:0]       sc;
        logic [7:0]       ec;

        x32 = {16'b0, i_x};
        hit = 1'b0;
        seg = 4'd0;
        // First segment whose upper breakpoint lies above the input
        for (int i = 0; i < pcr_pkg::SEGMENTS; i++) begin
            if (!hit && (x32 < (32'(pcr_pkg::BREAK_PCT[i+1]) << FRAC_BITS))) begin
                hit = 1'b1;
                seg = 4'(i);
            end
        end

        lo    = 32'(pcr_pkg::BREAK_PCT[seg]) << FRAC_BITS;
        hi    = 32'(pcr_pkg::BREAK_PCT[seg + 4'd1]) << FRAC_BITS;
        off   = OFF_W'(x32 - lo);
        span  = OFF_W'(hi - lo);
        s_rgb = pcr_pkg::STOP_RGB[seg];
        e_rgb = pcr_pkg::STOP_RGB[seg + 4'd1];
        o_wide = (pcr_pkg::BREAK_PCT[seg + 4'd1] - pcr_pkg::BREAK_PCT[seg])
                 == pcr_pkg::WIDE_PCT;

        // Rising channels count up from the start, falling ones up from the end
        for (int c = 0; c < 3; c++) begin
            sc = s_rgb[8*c +: 8];
            ec = e_rgb[8*c +: 8];
            if (!hit) begin
                o_base[c] = pcr_pkg::TOP_RGB[8*c +: 8];
                o_num[c]  = '0;
            end else if (ec >= sc) begin
                o_base[c] = sc;
                o_num[c]  = PROD_W'(ec - sc) * PROD_W'(off);
            end else begin
                o_base[c] = ec;
                o_num[c]  = PROD_W'(sc - ec) * PROD_W'(span - off);
            end
        end
    end

endmodule

@@ hw/rtl/pcr_back.sv @@
module pcr_back #(
    parameter int FRAC_BITS = 8,
    parameter int PROD_W    = 20
) (
    input  logic [2:0][7:0]         i_base,
    input  logic [2:0][PROD_W-1:0]  i_num,
    input  logic                    i_wide,
    output logic [2:0][7:0]         o_chan
);

    // Quotient by five stays exact for values below 2^16
    localparam int          DIV_W    = 11;
    localparam int          MUL_W    = DIV_W + 16;
    localparam logic [15:0] RECIP5   = 16'hCCCD;
    localparam int          RECIP_SH = 18;

    // Drop the fraction bits, halve for ten-wide segments, divide by five
    always_comb begin
        logic [PROD_W-1:0] sh;
        logic [DIV_W-1:0]  v;
        logic [MUL_W-1:0]  q;

        for (int c = 0; c < 3; c++) begin
            sh = i_num[c] >> FRAC_BITS;
            if (i_wide) begin
                sh = sh >> 1;
            end
            v = DIV_W'(sh);
            q = (MUL_W'(v) * MUL_W'(RECIP5)) >> RECIP_SH;
            o_chan[c] = i_base[c] + 8'(q);
        end
    end

endmodule

@@ hw/rtl/percent_heatmap_color_ramp.sv @@
// Heat-map color ramp: maps a fixed-point percentage to an RGB color.
// Input channel: i_valid / o_stall with i_percent_fixed, the percentage
// times 2^PERCENT_FRAC_BITS. A beat is taken at a rising edge where
// i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_red, o_green, o_blue (alpha is
// always FF and not carried). One output beat per input beat, in order.
// A beat passes the input register, product register and result
// register in order. Throughput: one beat per cycle while i_stall is low;
// the per-channel multiply by the segment offset sets the stage split.
// Each stage moves on when it is empty or the stage after it moves, so
// a stalled result holds in the output register while earlier stages
// keep filling; o_stall rises only once all three stages are full.
// Reset clears the three stage valid flags; the payload registers are not reset.
// Inputs at or above one hundred percent give the color A71F00.
module percent_heatmap_color_ramp #(
    parameter int PERCENT_FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_percent_fixed,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);

    localparam int OFF_W  = $clog2((10 << PERCENT_FRAC_BITS) + 1);
    localparam int PROD_W = OFF_W + 8;

    logic                   r_v1;
    logic [15:0]            r_x;
    logic                   r_v2;
    logic [2:0][7:0]        r_base;
    logic [2:0][PROD_W-1:0] r_num;
    logic                   r_wide;
    logic                   r_v3;
    logic [2:0][7:0]        r_chan;

    logic [2:0][7:0]        n_base;
    logic [2:0][PROD_W-1:0] n_num;
    logic                   n_wide;
    logic [2:0][7:0]        n_chan;

    logic                   adv1;
    logic                   adv2;
    logic                   adv3;

    // Each stage advances when empty or when its successor advances
    assign adv3    = !r_v3 || !i_stall;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;

    pcr_front #(
        .FRAC_BITS (PERCENT_FRAC_BITS),
        .OFF_W     (OFF_W),
        .PROD_W    (PROD_W)
    ) u_front (
        .i_x    (r_x),
        .o_base (n_base),
        .o_num  (n_num),
        .o_wide (n_wide)
    );

    pcr_back #(
        .FRAC_BITS (PERCENT_FRAC_BITS),
        .PROD_W    (PROD_W)
    ) u_back (
        .i_base (r_base),
        .i_num  (r_num),
        .i_wide (r_wide),
        .o_chan (n_chan)
    );

    // Track beat occupancy of the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Advance payload; hold it while the stage is stalled
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_x <= i_percent_fixed;
        end
        if (adv2) begin
            r_base <= n_base;
            r_num  <= n_num;
            r_wide <= n_wide;
        end
        if (adv3) begin
            r_chan <= n_chan;
        end
    end

    assign o_valid = r_v3;
    assign o_red   = r_chan[2];
    assign o_green = r_chan[1];
    assign o_blue  = r_chan[0];

endmodule

@@ bench/percent_heatmap_color_ramp_tb.sv @@
`timescale 1ns / 100ps

module percent_heatmap_color_ramp_tb;

    localparam int FRAC_BITS    = 8;
    localparam int PCT_ONE      = 1 << FRAC_BITS;
    localparam int KNOTS        = 13;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;

    // Ramp knots: whole percent and the color that sits there
    localparam int KNOT_PCT [KNOTS] = '{
        0, 5, 10, 20, 30, 40, 50, 60, 70, 80, 90, 95, 100
    };
    localparam logic [23:0] KNOT_RGB [KNOTS] = '{
        24'h003EFF, 24'h0094FF, 24'h00FFFF, 24'h00FF90, 24'h00FF21,
        24'h4CFF00, 24'hB6FF00, 24'hFFD800, 24'hFF6A00, 24'hFF2F00,
        24'hFF0000, 24'hFF006E, 24'hFD80B5
    };
    localparam logic [23:0] SATURATED_RGB = 24'hA71F00;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_percent_fixed;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;

    t_rgb pending_colors[$];
    int   send_idle_pct;
    int   recv_stall_pct;
    int   mismatch_count;
    int   quiet_cycles;

    percent_heatmap_color_ramp #(
        .PERCENT_FRAC_BITS(FRAC_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_percent_fixed(i_percent_fixed),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    // Blend one channel between the segment's start and end colors
    function automatic logic [7:0] blend_channel(int s, int e, int off, int span);
        if (e >= s) begin
            return 8'(s + ((e - s) * off) / span);
        end
        return 8'(e + ((s - e) * (span - off)) / span);
    endfunction

    // Expected ramp color for one percentage beat
    function automatic t_rgb ramp_color(logic [15:0] pct);
        int          seg;
        int          lo;
        int          hi;
        logic [23:0] s;
        logic [23:0] e;
        t_rgb        c;
        c = SATURATED_RGB;
        for (seg = 0; seg < KNOTS - 1; seg++) begin
            lo = KNOT_PCT[seg] * PCT_ONE;
            hi = KNOT_PCT[seg + 1] * PCT_ONE;
            if (int'(pct) >= lo && int'(pct) < hi) begin
                s = KNOT_RGB[seg];
                e = KNOT_RGB[seg + 1];
                c.red   = blend_channel(s[23:16], e[23:16], int'(pct) - lo, hi - lo);
                c.green = blend_channel(s[15:8], e[15:8], int'(pct) - lo, hi - lo);
                c.blue  = blend_channel(s[7:0], e[7:0], int'(pct) - lo, hi - lo);
            end
        end
        return c;
    endfunction

    // Random percentage: mostly in range, some near knots, some anywhere
    function automatic logic [15:0] pick_percent();
        int v;
        case ($urandom_range(9))
            0: begin
                v = $urandom_range(65535);
            end
            1, 2: begin
                v = KNOT_PCT[$urandom_range(KNOTS - 1)] * PCT_ONE + $urandom_range(4) - 2;
                if (v < 0) begin
                    v = 0;
                end
            end
            default: begin
                v = $urandom_range(100 * PCT_ONE - 1);
            end
        endcase
        return 16'(v);
    endfunction

    // Send one beat; entered and left at a falling edge
    task automatic send_percent(input logic [15:0] pct);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            i_percent_fixed = 16'($urandom);
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_percent_fixed = pct;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        pending_colors.push_back(ramp_color(pct));
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_valid = 1'b0;
        while (pending_colors.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Knots, last code of each segment, saturation and the top code
    task automatic test_knots();
        int k;
        for (k = 0; k < KNOTS; k++) begin
            send_percent(16'(KNOT_PCT[k] * PCT_ONE));
            if (k > 0) begin
                send_percent(16'(KNOT_PCT[k] * PCT_ONE - 1));
            end
        end
        send_percent(16'hFFFF);
    endtask

    // Random beats under one idle/stall profile
    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        int n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < count; n++) begin
            send_percent(pick_percent());
        end
    endtask

    // Let the pipe empty completely, then restart after an idle block
    task automatic test_drain_pause();
        int n;
        send_idle_pct  = 0;
        recv_stall_pct = 46;
        for (n = 0; n < 20; n++) begin
            send_percent(pick_percent());
        end
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        for (n = 0; n < 20; n++) begin
            send_percent(pick_percent());
        end
    endtask

    // Randomize the output stall each cycle
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Compare each output beat with the oldest expected color
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_colors.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected beat: got %02h%02h%02h", o_red, o_green, o_blue);
                end
            end else begin
                want = pending_colors.pop_front();
                if (o_red !== want.red || o_green !== want.green || o_blue !== want.blue) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("color mismatch: expected %02h%02h%02h, got %02h%02h%02h",
                                 want.red, want.green, want.blue, o_red, o_green, o_blue);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_percent_fixed = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_knots();
        test_random(340, 0, 0);
        test_random(340, 46, 0);
        test_drain_pause();
        test_random(340, 0, 46);
        test_random(340, 37, 37);

        // Drain, then idle for DRAIN_CYCLES to catch any stray beats
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && pending_colors.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
